@@ src/ppa_pkg.sv @@
// ppa_pkg: shared types and constants for the particle point attractor step.
// No dependencies.
package ppa_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned EpsRawC = ((1 << FracBits) + 500) / 1000;
  localparam logic [31:0] Eps = (EpsRawC == 0) ? 32'd1 : 32'(EpsRawC);

  localparam logic [2:0] RegCenterX = 3'd0;
  localparam logic [2:0] RegCenterY = 3'd1;
  localparam logic [2:0] RegCenterZ = 3'd2;
  localparam logic [2:0] RegRadius  = 3'd3;
  localparam logic [2:0] RegGain    = 3'd4;

  typedef enum logic [3:0] {
    StIdle,
    StSq,
    StSqrt,
    StMul,
    StDiv,
    StAcc,
    StOut
  } state_e;

endpackage

@@ src/ppa_divider.sv @@
// ppa_divider: shared unsigned restoring divider, one quotient bit per cycle.
// No dependencies.
module ppa_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [35:0] den_i,
  output logic        busy_o,
  output logic [63:0] quot_o
);
  logic [63:0] quot_q, quot_d;
  logic [36:0] rem_q, rem_d;
  logic [35:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [36:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    trial  = {rem_q[35:0], quot_q[63]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 7'd64;
    end else if (cnt_q != 7'd0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = (cnt_q != 7'd0) || start_i;
  assign quot_o = quot_q;
endmodule

@@ src/particle_point_attractor_step_top.sv @@
// particle_point_attractor_step_top: point attractor speed update per particle.
// Depends on ppa_pkg and ppa_divider.
//
// Channel | Dir | Content
// s_axis  | in  | tdata: pos_x,pos_y,pos_z,speed_x,speed_y,speed_z; tlast: frame_end
// m_axis  | out | tdata: new_speed_x/y/z; tuser: passed_through; tlast: frame_done
// apb     | in  | center_x/y/z, radius, attract_gain at 4*i
//
// An updated particle takes three squares, a radius test and 32 root steps, then per
// axis one multiply, a divide on the shared divider and one accumulate. A stopped frame
// skips to the output; an axis beyond the radius exits while squaring; a sum of squares
// beyond radius squared exits at the radius test. Input is taken only when idle with no
// result waiting; the result register holds until m_axis_tready. Reset clears the state
// machine, frame stop flag, output valid and configuration registers.
module particle_point_attractor_step_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [191:0] s_axis_tdata_i,  // pos_x, pos_y, pos_z, speed_x, speed_y, speed_z
  input  logic         s_axis_tlast_i,  // frame_end
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [95:0]  m_axis_tdata_o,  // new_speed_x, new_speed_y, new_speed_z
  output logic         m_axis_tuser_o,  // passed_through
  output logic         m_axis_tlast_o,  // frame_done
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [4:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);

  // Configuration registers.
  logic signed [31:0] cx_q, cy_q, cz_q, gain_q;
  logic [30:0] radius_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i;
  assign cfg_idx  = paddr_i[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; cz_q <= '0; radius_q <= '0; gain_q <= '0;
    end else if (cfg_we && paddr_i[1:0] == 2'b00) begin
      case (cfg_idx)
        ppa_pkg::RegCenterX: cx_q <= pwdata_i;
        ppa_pkg::RegCenterY: cy_q <= pwdata_i;
        ppa_pkg::RegCenterZ: cz_q <= pwdata_i;
        ppa_pkg::RegRadius:  radius_q <= pwdata_i[30:0];
        ppa_pkg::RegGain:    gain_q <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ppa_pkg::RegCenterX: prdata_o = cx_q;
      ppa_pkg::RegCenterY: prdata_o = cy_q;
      ppa_pkg::RegCenterZ: prdata_o = cz_q;
      ppa_pkg::RegRadius:  prdata_o = {1'b0, radius_q};
      ppa_pkg::RegGain:    prdata_o = gain_q;
      default:             prdata_o = '0;
    endcase
  end

  // Datapath state.
  ppa_pkg::state_e state_q, state_d;
  logic        stopped_q, stopped_d;
  logic [1:0]  axis_q, axis_d;       // axis under work
  logic [5:0]  step_q, step_d;       // root step counter
  logic signed [32:0] d_q [3];        // centre minus position
  logic signed [31:0] sp_q [3];
  logic        fend_q;
  logic [65:0] sum_q, sum_d;          // sum of squares, later root remainder
  logic [32:0] root_q, root_d;
  logic [63:0] prod_q, prod_d;
  logic        pass_q, pass_d;
  logic        ovalid_q;
  logic [95:0] odata_q;
  logic        ouser_q, olast_q;

  logic        accept;
  logic [32:0] mag [3];
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [61:0] rad_sq;
  logic        far;
  logic [35:0] den;
  logic        div_start, div_busy;
  logic [63:0] quot;
  logic signed [33:0] newsp;
  logic signed [31:0] sat;
  logic        neg;
  logic [31:0] gmag;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ppa_pkg::StIdle) && !ovalid_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = d_q[i][32] ? 33'(-d_q[i]) : 33'(d_q[i]);
    end
  end
  assign gmag = gain_q[31] ? 32'(-gain_q) : 32'(gain_q);

  // Shared multiplier: squares then |d|*|gain|; |d| never exceeds 32 bits.
  always_comb begin
    mul_a = mag[axis_q][31:0];
    mul_b = (state_q == ppa_pkg::StSq) ? mag[axis_q][31:0] : gmag;
    mul_p = 64'(mul_a) * 64'(mul_b);
  end
  assign rad_sq = 62'(radius_q) * 62'(radius_q);
  assign far = (mag[0] > {2'b0, radius_q}) || (mag[1] > {2'b0, radius_q}) ||
               (mag[2] > {2'b0, radius_q});

  // Root: one bit pair per cycle, 32 steps, digit-by-digit.
  assign den   = 36'(({3'b0, root_q} + 36'(ppa_pkg::Eps)) * 36'd10);
  assign neg   = d_q[axis_q][32] ^ gain_q[31];

  ppa_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_d),
    .den_i   (den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // A quotient of 2^32 or more always saturates.
  always_comb begin
    newsp = 34'(sp_q[axis_q]) + (neg ? -34'(quot[31:0]) : 34'(quot[31:0]));
    if (quot[63:32] != '0) newsp = neg ? -34'sd4294967296 : 34'sd4294967296;
    if (newsp > 34'sd2147483647)       sat = 32'h7fffffff;
    else if (newsp < -34'sd2147483648) sat = 32'h80000000;
    else                               sat = newsp[31:0];
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ppa_pkg::StIdle: if (accept) state_d = stopped_q ? ppa_pkg::StOut : ppa_pkg::StSq;
      ppa_pkg::StSq: begin
        if (far) state_d = ppa_pkg::StOut;
        else if (axis_q == 2'd2) state_d = ppa_pkg::StSqrt;
      end
      ppa_pkg::StSqrt: begin
        if (sum_q > 66'(rad_sq) && step_q == 6'd32) state_d = ppa_pkg::StOut;
        else if (step_q == 6'd0) state_d = ppa_pkg::StMul;
      end
      ppa_pkg::StMul: state_d = ppa_pkg::StDiv;
      ppa_pkg::StDiv: if (!div_busy) state_d = ppa_pkg::StAcc;
      ppa_pkg::StAcc: state_d = (axis_q == 2'd2) ? ppa_pkg::StOut : ppa_pkg::StMul;
      ppa_pkg::StOut: state_d = ppa_pkg::StIdle;
      default: state_d = ppa_pkg::StIdle;
    endcase
  end

  // Datapath control.
  always_comb begin
    axis_d = axis_q; step_d = step_q; sum_d = sum_q; root_d = root_q;
    prod_d = prod_q; pass_d = pass_q; stopped_d = stopped_q; div_start = 1'b0;
    case (state_q)
      ppa_pkg::StIdle: begin
        axis_d = 2'd0; sum_d = '0; root_d = '0; pass_d = 1'b1;
      end
      ppa_pkg::StSq: begin
        sum_d = sum_q + 66'(mul_p);
        axis_d = (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
        step_d = 6'd32;
        if (far) stopped_d = 1'b1;
      end
      ppa_pkg::StSqrt: begin
        if (step_q == 6'd32) begin
          // Test radius, then keep the value in prod for the root.
          if (sum_q > 66'(rad_sq)) stopped_d = 1'b1;
          prod_d = sum_q[63:0];
          sum_d  = '0;
          step_d = 6'd31;
        end else begin
          // Restoring root: remainder in sum, next two bits from prod.
          if ({sum_q[63:0], prod_q[63:62]} >= {root_q[31:0], 2'b01}) begin
            sum_d  = 66'({sum_q[63:0], prod_q[63:62]} - {root_q[31:0], 2'b01});
            root_d = {root_q[31:0], 1'b1};
          end else begin
            sum_d  = 66'({sum_q[63:0], prod_q[63:62]});
            root_d = {root_q[31:0], 1'b0};
          end
          prod_d = {prod_q[61:0], 2'b00};
          step_d = (step_q == 6'd0) ? 6'd0 : step_q - 6'd1;
        end
      end
      ppa_pkg::StMul: begin
        prod_d = mul_p;
        div_start = 1'b1;
        pass_d = 1'b0;
      end
      ppa_pkg::StAcc: axis_d = axis_q + 2'd1;
      default: ;
    endcase
    if (state_q == ppa_pkg::StOut && fend_q) stopped_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppa_pkg::StIdle;
      stopped_q <= 1'b0;
      ovalid_q <= 1'b0;
      axis_q <= '0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      stopped_q <= stopped_d;
      axis_q <= axis_d;
      step_q <= step_d;
      if (state_q == ppa_pkg::StOut) ovalid_q <= 1'b1;
      else if (m_axis_tready_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d; root_q <= root_d; prod_q <= prod_d; pass_q <= pass_d;
    if (accept) begin
      d_q[0] <= 33'(cx_q) - 33'($signed(s_axis_tdata_i[31:0]));
      d_q[1] <= 33'(cy_q) - 33'($signed(s_axis_tdata_i[63:32]));
      d_q[2] <= 33'(cz_q) - 33'($signed(s_axis_tdata_i[95:64]));
      sp_q[0] <= s_axis_tdata_i[127:96];
      sp_q[1] <= s_axis_tdata_i[159:128];
      sp_q[2] <= s_axis_tdata_i[191:160];
      fend_q <= s_axis_tlast_i;
    end
    if (state_q == ppa_pkg::StAcc) sp_q[axis_q] <= sat;
    if (state_q == ppa_pkg::StOut) begin
      odata_q <= {sp_q[2], sp_q[1], sp_q[0]};
      ouser_q <= pass_q;
      olast_q <= fend_q;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

@@ src/ppa_checker.sv @@
// ppa_checker: port-level checks for the attractor step block.
// Depends on particle_point_attractor_step_top ports; bound below.
module ppa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [95:0] m_axis_tdata_o,
  input logic        pready_o
);
  // One request in flight: no new input while a result waits.
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o) else $error("accept while result pending");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o) else $error("ready after accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result dropped");
  a_pready: assert property (@(posedge clk_i) pready_o) else $error("pready low");
endmodule

bind particle_point_attractor_step_top ppa_checker u_ppa_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o), .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i), .m_axis_tdata_o(m_axis_tdata_o),
  .pready_o(pready_o));
